// ===== rtl/core/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// Shared types, register indexes and the quadrature transition table of the
// two-channel detent decoder.
// ----------------------------------------------------------------------------
package qdd_pkg;

  // Field widths.
  localparam int unsigned THR_W     = 3;
  localparam int unsigned DIR_W     = 2;
  localparam int unsigned PINS_W    = 2;
  localparam int unsigned ACC_W     = 4;
  localparam int unsigned DELTA_W   = 8;
  localparam int unsigned STEP_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DETENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_SECOND = 2'd2;

  // Reset values of the registers.
  localparam logic [THR_W-1:0] STEPS_RESET = 3'd4;
  localparam logic [DIR_W-1:0] DIR_RESET   = 2'b01;

  // Direction codes: only the sign of the code matters.
  localparam logic [DIR_W-1:0] DIR_ZERO = 2'b00;
  localparam logic [DIR_W-1:0] DIR_PLUS = 2'b01;

  // Input action codes.
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  // Saturation limits of the pending detent counts.
  localparam logic signed [DELTA_W-1:0] DELTA_MAX = 8'sd127;
  localparam logic signed [DELTA_W-1:0] DELTA_MIN = -8'sd127;

  typedef logic signed [STEP_W-1:0]  step_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [DELTA_W-1:0] delta_t;
  typedef logic [PINS_W-1:0]         pins_t;

  // Transition table indexed by {previous, current} active-low pin pairs.
  localparam step_t STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  function automatic step_t step_lookup(input pins_t prev, input pins_t cur);
    return STEP_TABLE[{prev, cur}];
  endfunction

  // Applies a direction code to a step: +1 keeps, 0 kills, negative codes flip.
  function automatic step_t apply_direction(input step_t step, input logic [DIR_W-1:0] dir);
    step_t res;
    res = step;
    if (dir == DIR_ZERO) begin
      res = '0;
    end else if (dir != DIR_PLUS) begin
      res = -step;
    end
    return res;
  endfunction

endpackage

// ===== rtl/core/qdd_if.sv =====
// ----------------------------------------------------------------------------
// qdd_if
// Valid/ready channels of the detent decoder: sample/read items in, results out.
// ----------------------------------------------------------------------------
interface qdd_in_if;
  logic valid;
  logic ready;
  logic action;
  logic encoder_select;
  logic pin_a_level;
  logic pin_b_level;

  modport source (output valid, action, encoder_select, pin_a_level, pin_b_level,
                  input ready);
  modport sink   (input valid, action, encoder_select, pin_a_level, pin_b_level,
                  output ready);
endinterface

interface qdd_out_if;
  logic               valid;
  logic               ready;
  logic signed [7:0]  delta_first;
  logic signed [7:0]  delta_second;
  logic signed [1:0]  detent_step;

  modport source (output valid, delta_first, delta_second, detent_step, input ready);
  modport sink   (input valid, delta_first, delta_second, detent_step, output ready);
endinterface

// ===== rtl/core/quadrature_detent_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_decoder_unit
// Decodes the A/B pins of two rotary encoders into saturating detent counts.
// ----------------------------------------------------------------------------
// Usage:
//   samples carries one item per transfer: either a pin sample of one encoder
//   (action 0) or a read request (action 1) that returns both pending detent
//   counts and clears them. results carries one item per accepted input.
//   The configuration port writes steps_per_detent and the two direction
//   codes; write it only while no item is in flight.
// Timing:
//   Per-encoder state is updated at the edge that accepts the item, and the
//   result is registered there, so it shows on results in the next cycle.
//   One item per cycle is sustained while results is not stalled; the table
//   lookup, accumulator add and threshold compare are all combinational.
// Reset and stalls:
//   rst clears the accumulators and pending counts, sets both previous pin
//   pairs to idle (pins high) and loads the register defaults. While a
//   result waits on a stalled receiver, samples.ready is low; it rises in
//   the same cycle the result is taken, so no bubble is added.
// ----------------------------------------------------------------------------
module quadrature_detent_decoder_unit
  import qdd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  qdd_in_if.sink               samples,
  qdd_out_if.source            results
);

  // Configuration registers.
  logic [THR_W-1:0] steps_per_detent;
  logic [DIR_W-1:0] direction_first;
  logic [DIR_W-1:0] direction_second;

  // Per-encoder state.
  pins_t  previous_pins    [2];
  acc_t   step_accumulator [2];
  delta_t pending_detents  [2];

  // Result register.
  logic   out_valid;
  delta_t out_delta_first;
  delta_t out_delta_second;
  step_t  out_detent_step;

  logic accept;

  // Next-state values for the selected encoder.
  logic                    sel;
  pins_t                   cur;
  pins_t                   prev;
  logic                    changed;
  step_t                   step;
  step_t                   dstep;
  logic signed [ACC_W:0]   acc_sum;
  logic signed [ACC_W:0]   thr;
  acc_t                    acc_next;
  delta_t                  pend_next;
  step_t                   detent;

  // The input side moves whenever the result register is empty or draining.
  assign samples.ready = !out_valid || results.ready;
  assign accept        = samples.valid && samples.ready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_detent <= STEPS_RESET;
      direction_first  <= DIR_RESET;
      direction_second <= DIR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STEPS_PER_DETENT: steps_per_detent <= cfg_data;
        REG_DIRECTION_FIRST:  direction_first  <= cfg_data[DIR_W-1:0];
        REG_DIRECTION_SECOND: direction_second <= cfg_data[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Transition lookup, accumulation and detent threshold for one sample.
  always_comb begin
    sel      = samples.encoder_select;
    cur      = {~samples.pin_a_level, ~samples.pin_b_level};
    prev     = previous_pins[sel];
    changed  = (cur != prev);
    step     = step_lookup(prev, cur);
    dstep    = apply_direction(step, sel ? direction_second : direction_first);
    acc_sum  = {step_accumulator[sel][ACC_W-1], step_accumulator[sel]}
               + {{(ACC_W+1-STEP_W){dstep[STEP_W-1]}}, dstep};
    thr      = {{(ACC_W+1-THR_W){1'b0}}, steps_per_detent};
    acc_next = acc_sum[ACC_W-1:0];
    pend_next = pending_detents[sel];
    detent   = '0;
    if (changed) begin
      if (step == '0) begin
        acc_next = '0;
      end else if (acc_sum >= thr) begin
        detent   = 2'sd1;
        acc_next = '0;
        if (pending_detents[sel] < DELTA_MAX) begin
          pend_next = pending_detents[sel] + 8'sd1;
        end
      end else if (acc_sum <= -thr) begin
        detent   = -2'sd1;
        acc_next = '0;
        if (pending_detents[sel] > DELTA_MIN) begin
          pend_next = pending_detents[sel] - 8'sd1;
        end
      end
    end else begin
      acc_next = step_accumulator[sel];
    end
  end

  // Encoder state update on each accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        previous_pins[i]    <= '0;
        step_accumulator[i] <= '0;
        pending_detents[i]  <= '0;
      end
    end else if (accept) begin
      if (samples.action == ACT_READ) begin
        pending_detents[0] <= '0;
        pending_detents[1] <= '0;
      end else begin
        previous_pins[sel]    <= cur;
        step_accumulator[sel] <= acc_next;
        pending_detents[sel]  <= pend_next;
      end
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (samples.ready) begin
      out_valid <= samples.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      if (samples.action == ACT_READ) begin
        out_delta_first  <= pending_detents[0];
        out_delta_second <= pending_detents[1];
        out_detent_step  <= '0;
      end else begin
        out_delta_first  <= '0;
        out_delta_second <= '0;
        out_detent_step  <= detent;
      end
    end
  end

  assign results.valid        = out_valid;
  assign results.delta_first  = out_delta_first;
  assign results.delta_second = out_delta_second;
  assign results.detent_step  = out_detent_step;

endmodule
